// File: hdl/fircv_pkg.sv
// fircv_pkg: widths, types and sizes shared by the fir convolution unit
// no dependencies; compiled first

package fircv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int OUT_W    = 35;
    localparam int NCOEF    = 8;
    localparam int TAPS_DEF = 8;
    localparam int FILL_W   = 3;
    localparam int IDX_W    = 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [OUT_W-1:0]    out_t;
    typedef logic [FILL_W-1:0]          fill_t;
    typedef logic [IDX_W-1:0]           cfg_idx_t;
    typedef prod_t                      prod_arr_t [NCOEF];

endpackage

// File: hdl/fircv_if.sv
// fircv channel interfaces: sample input, filtered output, coefficient writes
// depends on fircv_pkg

interface fircv_in_if;
    logic              valid;
    logic              ready;
    fircv_pkg::sample_t sample;
    logic              block_start;

    modport source (output valid, output sample, output block_start, input ready);
    modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface fircv_out_if;
    logic           valid;
    logic           ready;
    fircv_pkg::out_t filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

interface fircv_cfg_if;
    logic                valid;
    logic                ready;
    fircv_pkg::cfg_idx_t index;
    fircv_pkg::coef_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/fircv_tap_cell.sv
// fircv_tap_cell: one tap of the delay row, holds one past sample when KEEP is set
// and registers coefficient times the sample at its lag; depends on fircv_pkg

module fircv_tap_cell #(
    parameter bit KEEP = 1'b1
) (
    input  logic              clk,
    input  logic              en,
    input  fircv_pkg::coef_t   coef,
    input  fircv_pkg::sample_t tap_in,
    output fircv_pkg::sample_t hold_out,
    output fircv_pkg::prod_t   product
);
    import fircv_pkg::*;

    prod_t product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= coef * tap_in;
        end
    end

    assign product = product_reg;

    generate
        if (KEEP)
        begin : g_hold
            sample_t hold_reg;

            // sample moves one place down the row on every accepted request
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    hold_reg <= tap_in;
                end
            end

            assign hold_out = hold_reg;
        end
        else
        begin : g_last
            assign hold_out = tap_in;
        end
    endgenerate

endmodule

// File: hdl/fircv_add_tree.sv
// fircv_add_tree: registered three-level adder tree over the tap products,
// with a valid/ready handshake per level; depends on fircv_pkg

module fircv_add_tree (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fircv_pkg::prod_arr_t products,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fircv_pkg::out_t      sum
);
    import fircv_pkg::*;

    localparam int N1 = NCOEF / 2;
    localparam int N2 = NCOEF / 4;

    logic signed [PROD_W:0]   lvl1_reg [N1];
    logic signed [PROD_W+1:0] lvl2_reg [N2];
    out_t                     sum_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic                     rdy1;
    logic                     rdy2;
    logic                     rdy3;

    // a level takes new data when empty or when the level after it moves
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            for (int k = 0; k < N1; k++)
            begin
                lvl1_reg[k] <= (PROD_W+1)'(products[2*k]) + (PROD_W+1)'(products[2*k+1]);
            end
        end
        if (rdy2)
        begin
            for (int k = 0; k < N2; k++)
            begin
                lvl2_reg[k] <= (PROD_W+2)'(lvl1_reg[2*k]) + (PROD_W+2)'(lvl1_reg[2*k+1]);
            end
        end
        if (rdy3)
        begin
            sum_reg <= OUT_W'(lvl2_reg[0]) + OUT_W'(lvl2_reg[1]);
        end
    end

    assign out_valid = v3_reg;
    assign sum       = sum_reg;

endmodule

// File: hdl/fir_filter_convolution_unit.sv
// fir_filter_convolution_unit: streaming direct-form fir, valid-convolution output
// depends on fircv_pkg, fircv_if, fircv_tap_cell, fircv_add_tree

// Takes one signed 16-bit sample per clock while the output is not stalled
// and, once TAPS samples of the current block have been seen, gives the
// exact 35-bit sum of coef_j times the sample j places back; block_start
// restarts the fill so earlier samples never contribute. A row of tap cells
// holds the history and registers one 16x16 product per tap, then a
// three-level registered adder tree sums them; a result is offered after the
// product registers and the three tree levels. Each level holds its data
// under output stall, so samples keep being taken while bubbles remain in
// the pipeline. Coefficients are written through cfg (index 0..7) and are
// used by the next sample after the write; there is no clearing pass after reset.

module fir_filter_convolution_unit #(
    parameter int TAPS = fircv_pkg::TAPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    fircv_in_if.sink           samples,
    fircv_out_if.source        results,
    fircv_cfg_if.sink          cfg
);
    import fircv_pkg::*;

    coef_t     coef_reg [NCOEF];
    fill_t     fill_reg;
    fill_t     fill_next;
    fill_t     fill_base;
    logic      p_valid_reg;
    logic      accept;
    logic      hit;
    logic      ready1;
    logic      tree_ready;
    sample_t   taps [TAPS];
    prod_arr_t prods;

    // coefficient registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            coef_reg[cfg.index] <= cfg.data;
        end
    end

    // fill tracking; a start flag makes this sample the first of its block
    assign accept    = samples.valid && samples.ready;
    assign fill_base = samples.block_start ? '0 : fill_reg;
    assign hit       = fill_base >= FILL_W'(TAPS - 1);
    assign fill_next = hit ? fill_base : fill_base + 1'b1;

    assign ready1        = !p_valid_reg || tree_ready;
    assign samples.ready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            if (ready1)
            begin
                p_valid_reg <= accept && hit;
            end
        end
    end

    assign taps[0] = samples.sample;

    generate
        for (genvar j = 0; j < NCOEF; j++)
        begin : g_tap
            if (j < TAPS - 1)
            begin : g_mid
                fircv_tap_cell #(
                    .KEEP (1'b1)
                ) u_cell (
                    .clk      (clk),
                    .en       (accept),
                    .coef     (coef_reg[j]),
                    .tap_in   (taps[j]),
                    .hold_out (taps[j+1]),
                    .product  (prods[j])
                );
            end
            else if (j == TAPS - 1)
            begin : g_end
                fircv_tap_cell #(
                    .KEEP (1'b0)
                ) u_cell (
                    .clk      (clk),
                    .en       (accept),
                    .coef     (coef_reg[j]),
                    .tap_in   (taps[j]),
                    .hold_out (),
                    .product  (prods[j])
                );
            end
            else
            begin : g_unused
                assign prods[j] = '0;
            end
        end
    endgenerate

    fircv_add_tree u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p_valid_reg),
        .in_ready  (tree_ready),
        .products  (prods),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sum       (results.filtered)
    );

`ifndef NO_ASSERTIONS
    fill_bound_a : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TAPS - 1))
        else $error("fill count beyond tap count");

    start_no_result_a : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && samples.block_start && (TAPS > 1)) |=> !p_valid_reg)
        else $error("result issued for first sample of a block");

    full_gives_result_a : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !samples.block_start && (fill_reg == FILL_W'(TAPS - 1)))
        |=> p_valid_reg)
        else $error("filled history produced no result");
`endif

endmodule
